// ----- rtl/core/vrt_pkg.sv -----
`default_nettype none
package vrt_pkg;

	localparam int FIX = 24;
	localparam int RATIO_FRAC = 13;
	localparam int RATIO_MIN = 2048;
	localparam int IW = 26;
	localparam int UW = 72;
	localparam int DIV1_STEPS = 37;
	localparam int DIV2_STEPS = 32;
	localparam int SQRT_STEPS = 32;

	typedef logic [UW-1:0] uw_t;
	typedef logic signed [IW-1:0] cmp_t;
	typedef logic signed [31:0] w32_t;
	typedef logic signed [51:0] p52_t;
	typedef logic signed [54:0] p55_t;
	typedef logic signed [59:0] p60_t;

	typedef struct packed {
		uw_t rem;
		uw_t quo;
	} div_t;

	typedef struct packed {
		uw_t x;
		uw_t root;
	} sqr_t;

	typedef struct packed {
		logic vld;
		cmp_t [2:0] iv;
		cmp_t [2:0] nv;
		logic [15:0] n;
		p52_t [2:0] p;
		logic signed [28:0] cosi;
		logic [32:0] c2;
		logic [31:0] n2;
		p55_t [2:0] nvc;
		logic signed [59:0] numer;
		w32_t [2:0] rs;
		logic [2:0][63:0] rr;
		logic [63:0] len2;
	} pre_t;

	typedef struct packed {
		logic vld;
		div_t rad;
		logic rad_neg;
		uw_t n2;
		div_t cn;
		logic cn_neg;
		div_t [2:0] iq;
		logic [2:0] iq_neg;
		uw_t nn;
		sqr_t len;
		cmp_t [2:0] nv;
		w32_t [2:0] rs;
	} dv_t;

	typedef struct packed {
		logic vld;
		logic tir;
		sqr_t sq;
		div_t [2:0] td;
		logic [2:0] td_neg;
		uw_t len;
		logic len_zero;
		w32_t cn;
		w32_t [2:0] iq;
		cmp_t [2:0] nv;
	} nr_t;

	typedef struct packed {
		logic vld;
		logic tir;
		logic signed [33:0] nc;
		w32_t [2:0] iq;
		w32_t [2:0] tq;
		cmp_t [2:0] nv;
		p60_t [2:0] m;
	} fin_t;

	// one restoring division step for quotient bit b
	function automatic div_t div_step(input div_t s, input uw_t dsh, input int unsigned b);
		div_t o;
		o = s;
		if (s.rem >= dsh) begin
			o.rem = s.rem - dsh;
			o.quo = s.quo | (uw_t'(1) << b);
		end
		return o;
	endfunction

	// one digit of the floor square root
	function automatic sqr_t sqrt_step(input sqr_t s, input uw_t bitv);
		sqr_t o;
		o = s;
		if (s.x >= s.root + bitv) begin
			o.x = s.x - (s.root + bitv);
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	function automatic uw_t abs64(input logic signed [63:0] v);
		logic [63:0] a;
		a = v[63] ? 64'(-v) : 64'(v);
		return uw_t'(a);
	endfunction

	function automatic logic signed [63:0] apply_sign(input uw_t m, input logic neg);
		logic signed [63:0] v;
		v = signed'(m[63:0]);
		return neg ? -v : v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/vector_refraction_with_tir_core.sv -----
// Throughput: one word per cycle; busy is never asserted.
// Depth is set by the 37-step rad divider followed by the 32-step square root.
// The receiver cannot stall; each result is shown for one cycle with done.
// arst_n clears the valid bits only; the datapath registers are not reset.
`default_nettype none
module vector_refraction_with_tir_core #(
	parameter int COMP_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] inc_x,
	input  logic signed [COMP_WIDTH-1:0] inc_y,
	input  logic signed [COMP_WIDTH-1:0] inc_z,
	input  logic signed [COMP_WIDTH-1:0] norm_x,
	input  logic signed [COMP_WIDTH-1:0] norm_y,
	input  logic signed [COMP_WIDTH-1:0] norm_z,
	input  logic [15:0]                  index_ratio,
	output logic                         done,
	output logic signed [COMP_WIDTH-1:0] out_x,
	output logic signed [COMP_WIDTH-1:0] out_y,
	output logic signed [COMP_WIDTH-1:0] out_z,
	output logic                         total_reflect,
	output logic                         saturated
);
	import vrt_pkg::*;

	localparam int IN_SHL = (COMP_WIDTH <= 26) ? 26 - COMP_WIDTH : 0;
	localparam int IN_SHR = (COMP_WIDTH > 26) ? COMP_WIDTH - 26 : 0;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic signed [COMP_WIDTH-1:0] OHI = COMP_WIDTH'(SAT_HI);
	localparam logic signed [COMP_WIDTH-1:0] OLO = COMP_WIDTH'(SAT_LO);

	function automatic cmp_t load_comp(input logic [COMP_WIDTH-1:0] raw);
		logic signed [31:0] v;
		v = 32'(signed'(raw));
		v = (v <<< IN_SHL) >>> IN_SHR;
		return cmp_t'(v);
	endfunction

	pre_t pre_s1, pre_s2, pre_s3, pre_s4, pre_s5, pre_s6, pre_s7;
	pre_t pre_n1, pre_n2, pre_n3, pre_n4, pre_n5, pre_n6, pre_n7;
	dv_t dv_in;
	dv_t dv_s [1:DIV1_STEPS];
	nr_t nr_in;
	nr_t nr_s [1:DIV2_STEPS];
	fin_t fin_n1, fin_n2, fin_s1, fin_s2;
	logic signed [63:0] rad_q, rad_v;
	logic signed [63:0] res_w [3];
	logic signed [63:0] shf_w [3];
	logic [2:0][COMP_WIDTH-1:0] oc_n, oc_s3;
	logic vld_s3, tir_s3, sat_s3, sat_n;

	assign busy = 1'b0;

	always_comb begin
		pre_n1 = pre_s1;
		pre_n1.vld = start && !busy;
		pre_n1.iv[0] = load_comp(inc_x);
		pre_n1.iv[1] = load_comp(inc_y);
		pre_n1.iv[2] = load_comp(inc_z);
		pre_n1.nv[0] = load_comp(norm_x);
		pre_n1.nv[1] = load_comp(norm_y);
		pre_n1.nv[2] = load_comp(norm_z);
		pre_n1.n = (index_ratio < 16'(RATIO_MIN)) ? 16'(RATIO_MIN) : index_ratio;
	end

	always_comb begin
		pre_n2 = pre_s1;
		for (int k = 0; k < 3; k++) begin
			pre_n2.p[k] = $signed(pre_s1.iv[k]) * $signed(pre_s1.nv[k]);
		end
	end

	always_comb begin
		pre_n3 = pre_s2;
		pre_n3.cosi = 29'(($signed(pre_s2.p[0]) >>> FIX) + ($signed(pre_s2.p[1]) >>> FIX)
			+ ($signed(pre_s2.p[2]) >>> FIX));
	end

	always_comb begin
		logic signed [57:0] csq;
		pre_n4 = pre_s3;
		csq = pre_s3.cosi * pre_s3.cosi;
		pre_n4.c2 = 33'(csq >>> FIX);
		pre_n4.n2 = 32'(pre_s3.n) * 32'(pre_s3.n);
		for (int k = 0; k < 3; k++) begin
			pre_n4.nvc[k] = $signed(pre_s3.nv[k]) * pre_s3.cosi;
		end
	end

	always_comb begin
		logic signed [33:0] dif;
		pre_n5 = pre_s4;
		dif = (34'sd1 <<< FIX) - $signed({1'b0, pre_s4.c2});
		pre_n5.numer = 60'(dif) <<< (2 * RATIO_FRAC);
		for (int k = 0; k < 3; k++) begin
			pre_n5.rs[k] = 32'((($signed(pre_s4.nvc[k]) >>> FIX) <<< 1)
				- 55'($signed(pre_s4.iv[k])));
		end
	end

	always_comb begin
		pre_n6 = pre_s5;
		for (int k = 0; k < 3; k++) begin
			pre_n6.rr[k] = $signed(pre_s5.rs[k]) * $signed(pre_s5.rs[k]);
		end
	end

	always_comb begin
		pre_n7 = pre_s6;
		pre_n7.len2 = pre_s6.rr[0] + pre_s6.rr[1] + pre_s6.rr[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1.vld <= 1'b0;
			pre_s2.vld <= 1'b0;
			pre_s3.vld <= 1'b0;
			pre_s4.vld <= 1'b0;
			pre_s5.vld <= 1'b0;
			pre_s6.vld <= 1'b0;
			pre_s7.vld <= 1'b0;
		end else begin
			pre_s1 <= pre_n1;
			pre_s2 <= pre_n2;
			pre_s3 <= pre_n3;
			pre_s4 <= pre_n4;
			pre_s5 <= pre_n5;
			pre_s6 <= pre_n6;
			pre_s7 <= pre_n7;
		end
	end

	// rad, cosi/n and I/n dividers, length square root
	always_comb begin
		dv_in = '0;
		dv_in.vld = pre_s7.vld;
		dv_in.rad.rem = abs64(64'(pre_s7.numer));
		dv_in.rad_neg = pre_s7.numer[59];
		dv_in.n2 = uw_t'(pre_s7.n2);
		dv_in.cn.rem = abs64(64'(pre_s7.cosi) <<< RATIO_FRAC);
		dv_in.cn_neg = pre_s7.cosi[28];
		dv_in.nn = uw_t'(pre_s7.n);
		dv_in.len.x = uw_t'(pre_s7.len2);
		for (int k = 0; k < 3; k++) begin
			dv_in.iq[k].rem = abs64(64'($signed(pre_s7.iv[k])) <<< RATIO_FRAC);
			dv_in.iq_neg[k] = pre_s7.iv[k][IW-1];
		end
		dv_in.nv = pre_s7.nv;
		dv_in.rs = pre_s7.rs;
	end

	for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_dv
		dv_t src;
		dv_t nxt;
		if (i == 0) begin : g_first
			assign src = dv_in;
		end else begin : g_next
			assign src = dv_s[i];
		end
		always_comb begin
			nxt = src;
			nxt.rad = div_step(src.rad, src.n2 << (DIV1_STEPS - 1 - i), DIV1_STEPS - 1 - i);
			nxt.cn = div_step(src.cn, src.nn << (DIV1_STEPS - 1 - i), DIV1_STEPS - 1 - i);
			for (int k = 0; k < 3; k++) begin
				nxt.iq[k] = div_step(src.iq[k], src.nn << (DIV1_STEPS - 1 - i),
					DIV1_STEPS - 1 - i);
			end
			if (i < SQRT_STEPS) begin
				nxt.len = sqrt_step(src.len, uw_t'(1) << (62 - 2 * (i % SQRT_STEPS)));
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[i+1].vld <= 1'b0;
			end else begin
				dv_s[i+1] <= nxt;
			end
		end
	end

	// refraction root and normalizing dividers
	always_comb begin
		nr_in = '0;
		nr_in.vld = dv_s[DIV1_STEPS].vld;
		rad_q = apply_sign(dv_s[DIV1_STEPS].rad.quo, dv_s[DIV1_STEPS].rad_neg);
		rad_v = (64'sd1 <<< FIX) - rad_q;
		nr_in.tir = rad_v[63];
		nr_in.sq.x = rad_v[63] ? '0 : (uw_t'(rad_v) << FIX);
		nr_in.len = dv_s[DIV1_STEPS].len.root;
		nr_in.len_zero = (dv_s[DIV1_STEPS].len.root == '0);
		nr_in.cn = 32'(apply_sign(dv_s[DIV1_STEPS].cn.quo, dv_s[DIV1_STEPS].cn_neg));
		for (int k = 0; k < 3; k++) begin
			nr_in.td[k].rem = abs64(64'(dv_s[DIV1_STEPS].rs[k])) << FIX;
			nr_in.td_neg[k] = dv_s[DIV1_STEPS].rs[k][31];
			nr_in.iq[k] = 32'(apply_sign(dv_s[DIV1_STEPS].iq[k].quo,
				dv_s[DIV1_STEPS].iq_neg[k]));
		end
		nr_in.nv = dv_s[DIV1_STEPS].nv;
	end

	for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_nr
		nr_t src;
		nr_t nxt;
		if (i == 0) begin : g_first
			assign src = nr_in;
		end else begin : g_next
			assign src = nr_s[i];
		end
		always_comb begin
			nxt = src;
			nxt.sq = sqrt_step(src.sq, uw_t'(1) << (62 - 2 * i));
			for (int k = 0; k < 3; k++) begin
				nxt.td[k] = div_step(src.td[k], src.len << (DIV2_STEPS - 1 - i),
					DIV2_STEPS - 1 - i);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nr_s[i+1].vld <= 1'b0;
			end else begin
				nr_s[i+1] <= nxt;
			end
		end
	end

	always_comb begin
		fin_n1 = '0;
		fin_n1.vld = nr_s[DIV2_STEPS].vld;
		fin_n1.tir = nr_s[DIV2_STEPS].tir;
		fin_n1.nc = $signed({3'b000, nr_s[DIV2_STEPS].sq.root[30:0]})
			- 34'(nr_s[DIV2_STEPS].cn);
		fin_n1.iq = nr_s[DIV2_STEPS].iq;
		fin_n1.nv = nr_s[DIV2_STEPS].nv;
		for (int k = 0; k < 3; k++) begin
			fin_n1.tq[k] = nr_s[DIV2_STEPS].len_zero ? '0
				: 32'(apply_sign(nr_s[DIV2_STEPS].td[k].quo, nr_s[DIV2_STEPS].td_neg[k]));
		end
	end

	always_comb begin
		fin_n2 = fin_s1;
		for (int k = 0; k < 3; k++) begin
			fin_n2.m[k] = fin_s1.nc * $signed(fin_s1.nv[k]);
		end
	end

	always_comb begin
		sat_n = 1'b0;
		for (int k = 0; k < 3; k++) begin
			res_w[k] = fin_s2.tir ? 64'($signed(fin_s2.tq[k]))
				: -64'($signed(fin_s2.iq[k])) - 64'($signed(fin_s2.m[k]) >>> FIX);
			shf_w[k] = (res_w[k] <<< IN_SHR) >>> IN_SHL;
			if (shf_w[k] > SAT_HI) begin
				oc_n[k] = OHI;
				sat_n = 1'b1;
			end else if (shf_w[k] < SAT_LO) begin
				oc_n[k] = OLO;
				sat_n = 1'b1;
			end else begin
				oc_n[k] = COMP_WIDTH'(shf_w[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s1.vld <= 1'b0;
			fin_s2.vld <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			fin_s1 <= fin_n1;
			fin_s2 <= fin_n2;
			vld_s3 <= fin_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		oc_s3 <= oc_n;
		tir_s3 <= fin_s2.tir;
		sat_s3 <= sat_n;
	end

	assign done = vld_s3;
	assign out_x = oc_s3[0];
	assign out_y = oc_s3[1];
	assign out_z = oc_s3[2];
	assign total_reflect = tir_s3;
	assign saturated = sat_s3;

	a_tir_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done && total_reflect |-> !saturated)
		else $error("normalized reflection was clamped");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> (out_x == OHI || out_x == OLO || out_y == OHI
			|| out_y == OLO || out_z == OHI || out_z == OLO))
		else $error("saturated flag without a clamped component");

	a_rad_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s[DIV1_STEPS].vld |-> dv_s[DIV1_STEPS].rad.rem < dv_s[DIV1_STEPS].n2)
		else $error("rad divider remainder not below divisor");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;

	localparam int CW = 16;
	localparam int N_RANDOM = 1600;
	localparam int N_CALM = 200;
	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic signed [CW-1:0] ix, iy, iz;
		logic signed [CW-1:0] nx, ny, nz;
		logic [15:0] ratio;
	} ray_t;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
		logic tir;
		logic sat;
	} dir_t;

	typedef struct {
		ray_t ray;
		bit typed;
		dir_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [CW-1:0] inc_x, inc_y, inc_z, norm_x, norm_y, norm_z;
	logic [15:0] index_ratio;
	logic done;
	logic signed [CW-1:0] out_x, out_y, out_z;
	logic total_reflect, saturated;

	dir_t pending_dirs[$];
	bit typed_flags[$];
	dir_t typed_dirs[$];
	int errors = 0;
	int quiet_cycles = 0;

	vector_refraction_with_tir_core #(.COMP_WIDTH(CW)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.inc_x(inc_x), .inc_y(inc_y), .inc_z(inc_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.index_ratio(index_ratio), .done(done),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.total_reflect(total_reflect), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [CW-1:0] to_comp(input longint v, inout logic sat);
		longint s;
		s = v >>> 10;
		if (s > 32767) begin
			s = 32767;
			sat = 1'b1;
		end else if (s < -32768) begin
			s = -32768;
			sat = 1'b1;
		end
		return CW'(s);
	endfunction

	function automatic dir_t bend_ray(input ray_t r);
		longint iv[3], nv[3], res[3];
		longint one, n, n2, cosi, c2, rad, len, sq, cn, nc;
		longint unsigned len2;
		dir_t o;
		one = longint'(1) << 24;
		iv[0] = longint'(r.ix) * 1024;
		iv[1] = longint'(r.iy) * 1024;
		iv[2] = longint'(r.iz) * 1024;
		nv[0] = longint'(r.nx) * 1024;
		nv[1] = longint'(r.ny) * 1024;
		nv[2] = longint'(r.nz) * 1024;
		n = longint'(r.ratio);
		if (n < 2048)
			n = 2048;
		n2 = n * n;
		cosi = 0;
		for (int k = 0; k < 3; k++)
			cosi += (iv[k] * nv[k]) >>> 24;
		c2 = (cosi * cosi) >>> 24;
		rad = one - ((one - c2) * (longint'(1) << 26)) / n2;
		o.tir = rad < 0;
		o.sat = 1'b0;
		if (o.tir) begin
			len2 = 0;
			for (int k = 0; k < 3; k++) begin
				res[k] = 2 * ((nv[k] * cosi) >>> 24) - iv[k];
				len2 += longint'(res[k] * res[k]);
			end
			len = longint'(floor_sqrt(len2));
			for (int k = 0; k < 3; k++)
				res[k] = (len == 0) ? 0 : (res[k] * one) / len;
		end else begin
			sq = longint'(floor_sqrt(longint'(rad) << 24));
			cn = (cosi * 8192) / n;
			nc = sq - cn;
			for (int k = 0; k < 3; k++)
				res[k] = -((iv[k] * 8192) / n) - ((nc * nv[k]) >>> 24);
		end
		o.x = to_comp(res[0], o.sat);
		o.y = to_comp(res[1], o.sat);
		o.z = to_comp(res[2], o.sat);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// accepted words and results, both sampled before the edge's updates
	always @(posedge clk) begin
		dir_t e;
		bit typed;
		if (arst_n && start && !busy) begin
			typed = typed_flags.pop_front();
			e = typed_dirs.pop_front();
			pending_dirs.push_back(typed ? e : bend_ray('{inc_x, inc_y, inc_z,
				norm_x, norm_y, norm_z, index_ratio}));
		end
		if (arst_n && done) begin
			if (pending_dirs.size() == 0) begin
				$display("%0t: result word with nothing expected", $realtime);
				errors++;
			end else begin
				e = pending_dirs.pop_front();
				if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
				if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
				if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
				if (total_reflect !== e.tir)
					report_mismatch("total_reflect", total_reflect, e.tir);
				if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
			end
		end
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// leaves start high; the caller lowers it when it idles
	task automatic send_ray(input ray_t r, input bit typed, input dir_t want);
		typed_flags.push_back(typed);
		typed_dirs.push_back(want);
		start <= 1'b1;
		inc_x <= r.ix;
		inc_y <= r.iy;
		inc_z <= r.iz;
		norm_x <= r.nx;
		norm_y <= r.ny;
		norm_z <= r.nz;
		index_ratio <= r.ratio;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 9)) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] near_unit();
		return CW'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		if ($urandom_range(0, 9) < 6) begin
			r = '{near_unit(), near_unit(), near_unit(),
				near_unit(), near_unit(), near_unit(), 16'($urandom_range(4096, 16384))};
		end else begin
			r = '{CW'($urandom), CW'($urandom), CW'($urandom),
				CW'($urandom), CW'($urandom), CW'($urandom), 16'($urandom)};
		end
		return r;
	endfunction

	row_t rows[] = '{
		'{'{0, 0, 0, 0, 0, 0, 16'd8192}, 1, '{0, 0, 0, 0, 0}},
		'{'{0, 0, 0, 0, 0, 0, 16'd4096}, 1, '{0, 0, 0, 1, 0}},
		'{'{16384, 0, 0, 16384, 0, 0, 16'd8192}, 1, '{-16384, 0, 0, 0, 0}},
		'{'{0, 16384, 0, 0, 16384, 0, 16'd8192}, 1, '{0, -16384, 0, 0, 0}},
		'{'{0, 0, -16384, 0, 0, -16384, 16'd8192}, 1, '{0, 0, 16384, 0, 0}},
		'{'{16384, 0, 0, 0, 0, 0, 16'd0}, 0, '{0, 0, 0, 0, 0}},
		'{'{16384, 0, 0, 0, 0, 0, 16'd2047}, 0, '{0, 0, 0, 0, 0}},
		'{'{16384, 0, 0, 0, 0, 0, 16'd2048}, 0, '{0, 0, 0, 0, 0}},
		'{'{16384, 0, 0, 0, 0, 0, 16'd65535}, 0, '{0, 0, 0, 0, 0}},
		'{'{-32768, 0, 0, -32768, 0, 0, 16'd2048}, 0, '{0, 0, 0, 0, 0}},
		'{'{32767, 32767, 32767, 32767, 32767, 32767, 16'd2048}, 0, '{0, 0, 0, 0, 0}},
		'{'{-32768, -32768, -32768, -32768, -32768, -32768, 16'd65535}, 0,
			'{0, 0, 0, 0, 0}},
		'{'{-32768, -32768, -32768, 0, 0, 0, 16'd2048}, 0, '{0, 0, 0, 0, 0}},
		'{'{32767, -32768, 32767, -32768, 32767, -32768, 16'd12000}, 0,
			'{0, 0, 0, 0, 0}},
		'{'{11585, -11585, 0, 0, 16384, 0, 16'd12288}, 0, '{0, 0, 0, 0, 0}},
		'{'{11585, -11585, 0, 0, 16384, 0, 16'd5461}, 0, '{0, 0, 0, 0, 0}},
		'{'{8192, 14189, 0, 0, -16384, 0, 16'd10923}, 0, '{0, 0, 0, 0, 0}},
		'{'{-1, -1, -1, -1, -1, -1, 16'hffff}, 0, '{0, 0, 0, 0, 0}}
	};

	initial begin
		dir_t none;
		none = '{0, 0, 0, 0, 0};
		arst_n = 1'b0;
		start = 1'b0;
		inc_x = '0;
		inc_y = '0;
		inc_z = '0;
		norm_x = '0;
		norm_y = '0;
		norm_z = '0;
		index_ratio = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_ray(rows[i].ray, rows[i].typed, rows[i].res);
			if ($urandom_range(0, 3) == 0)
				idle_burst();
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				start <= 1'b0;
				while (pending_dirs.size() != 0 || typed_flags.size() != 0)
					@(posedge clk);
			end
			send_ray(random_ray(), 0, none);
			if (i < N_RANDOM - N_CALM && (i / 100) % 2 == 0 && $urandom_range(0, 4) == 0)
				idle_burst();
		end
		start <= 1'b0;

		while (pending_dirs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

// ----- vector_refraction_with_tir_core.f -----
rtl/core/vrt_pkg.sv
rtl/core/vector_refraction_with_tir_core.sv
test/tb.sv
